>>> rtl/core/packed_pixel_hline_fill_macros.svh
// ----------------------------------------------------------------------------
// packed_pixel_hline_fill assertion macros
// shared concurrent assertion forms used by the span fill block
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_HLINE_FILL_MACROS_SVH
`define PACKED_PIXEL_HLINE_FILL_MACROS_SVH

// same-cycle implication
`define PPHF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pphf same-cycle check failed");

// next-cycle implication
`define PPHF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pphf next-cycle check failed");

`endif

>>> rtl/core/pphf_pkg.sv
// ----------------------------------------------------------------------------
// pphf_pkg
// constants, types and helper functions of the packed-pixel span fill block
// ----------------------------------------------------------------------------
package pphf_pkg;

   localparam int SCREEN_WIDTH   = 640;
   localparam int SCREEN_HEIGHT  = 480;
   localparam int BITS_PER_PIXEL = 4;
   localparam int WORD_BITS      = 32;

   localparam int PIX_PER_WORD = WORD_BITS / BITS_PER_PIXEL;
   localparam int TOTAL_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int FB_WORDS     = (TOTAL_PIXELS + PIX_PER_WORD - 1) / PIX_PER_WORD;
   localparam int FB_ADDR_BITS = $clog2(FB_WORDS);
   localparam int PIX_BITS     = $clog2(TOTAL_PIXELS);
   localparam int SLOT_BITS    = $clog2(PIX_PER_WORD);
   localparam int ROW_BITS     = $clog2(SCREEN_HEIGHT);
   localparam int COLOR_MAX    = (1 << BITS_PER_PIXEL) - 1;

   localparam int X_BITS         = 12;
   localparam int COLOR_BITS     = 8;
   localparam int WADDR_BITS     = 16;
   localparam int STATUS_BITS    = 2;
   localparam int RDATA_BITS     = 32;
   localparam int CLIP_X_BITS    = 10;
   localparam int CLIP_Y_BITS    = 9;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_CLIPPED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECT  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_TOP    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_BOTTOM = 2'd3;

   localparam logic [CLIP_X_BITS-1:0] CLIP_LEFT_RESET   = 10'd0;
   localparam logic [CLIP_X_BITS-1:0] CLIP_RIGHT_RESET  = 10'd639;
   localparam logic [CLIP_Y_BITS-1:0] CLIP_TOP_RESET    = 9'd0;
   localparam logic [CLIP_Y_BITS-1:0] CLIP_BOTTOM_RESET = 9'd479;

   typedef struct packed {
      logic [CLIP_X_BITS-1:0] left;
      logic [CLIP_X_BITS-1:0] right;
      logic [CLIP_Y_BITS-1:0] top;
      logic [CLIP_Y_BITS-1:0] bottom;
   } clip_cfg_type;

   typedef struct packed {
      logic                    write;
      logic                    read;
      logic [FB_ADDR_BITS-1:0] address;
      logic [WORD_BITS-1:0]    data;
   } ram_req_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_ADDR,
      ST_WORD,
      ST_MERGE
   } state_type;

   // pixel slots lo..hi of a word, slot 0 in the top bits
   function automatic logic [WORD_BITS-1:0] span_mask(input logic [SLOT_BITS-1:0] lo,
                                                      input logic [SLOT_BITS-1:0] hi);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int k = 0; k < PIX_PER_WORD; k++) begin
         if (k >= int'(lo) && k <= int'(hi)) begin
            m[(PIX_PER_WORD-1-k)*BITS_PER_PIXEL +: BITS_PER_PIXEL] = '1;
         end
      end
      return m;
   endfunction

   function automatic logic [WORD_BITS-1:0] fill_word(input logic [BITS_PER_PIXEL-1:0] color);
      logic [WORD_BITS-1:0] w;
      w = '0;
      for (int k = 0; k < PIX_PER_WORD; k++) begin
         w[k*BITS_PER_PIXEL +: BITS_PER_PIXEL] = color;
      end
      return w;
   endfunction

endpackage

>>> rtl/core/packed_pixel_hline_fill.sv
// ----------------------------------------------------------------------------
// packed_pixel_hline_fill
// horizontal span fill into an internal packed-pixel framebuffer
//
// start is taken when busy is low; req_command selects a line draw or a word
// read. every item gives one result, held on rsp_status and rsp_read_data
// for one cycle while rsp_strobe is high; the receiver cannot stall it.
// the clip window is set through csr_write_enable, csr_index and
// csr_write_data; the user writes it only while busy is low, which the
// block does not enforce. a read in range is answered from the read state
// after the registered ram read, one out of range from the idle state.
// a rejected draw is answered from the check state; a drawn line passes
// the check and address states, then writes each whole span word and reads
// and merges each partial edge word, one single-port ram access per cycle.
// the next item is accepted in the cycle its predecessor's result shows.
// after reset the framebuffer ram is swept to zero, one word a cycle,
// all 38400 words, during which busy stays high; clip registers reset at once.
// ----------------------------------------------------------------------------
module packed_pixel_hline_fill (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [pphf_pkg::X_BITS-1:0]          req_x_start,
   input  logic [pphf_pkg::X_BITS-1:0]          req_x_end,
   input  logic [pphf_pkg::X_BITS-1:0]          req_row,
   input  logic [pphf_pkg::COLOR_BITS-1:0]      req_pixel_color,
   input  logic [pphf_pkg::WADDR_BITS-1:0]      req_word_address,
   output logic                                 rsp_strobe,
   output logic [pphf_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [pphf_pkg::RDATA_BITS-1:0]      rsp_read_data,
   input  logic                                 csr_write_enable,
   input  logic [pphf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pphf_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import pphf_pkg::*;

`include "packed_pixel_hline_fill_macros.svh"

   clip_cfg_type         clip_cfg;
   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] ram_rdata;

   pphf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .clip_cfg         (clip_cfg)
   );

   pphf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_row          (req_row),
      .req_pixel_color  (req_pixel_color),
      .req_word_address (req_word_address),
      .clip_cfg         (clip_cfg),
      .ram_req          (ram_req),
      .ram_rdata        (ram_rdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data)
   );

   pphf_ram #(
      .DEPTH     (FB_WORDS),
      .DATA_BITS (WORD_BITS),
      .ADDR_BITS (FB_ADDR_BITS)
   ) u_fb_ram (
      .clock        (clock),
      .write_enable (ram_req.write),
      .read_enable  (ram_req.read),
      .address      (ram_req.address),
      .write_data   (ram_req.data),
      .read_data    (ram_rdata)
   );

   `PPHF_ASSERT_NEXT(a_draw_goes_busy, clock, reset, start && !busy && req_command == CMD_DRAW, busy)
   `PPHF_ASSERT_IMPLY(a_result_when_idle, clock, reset, rsp_strobe, !busy)
   `PPHF_ASSERT_IMPLY(a_reject_no_data, clock, reset, rsp_strobe && rsp_status == STATUS_REJECT, rsp_read_data == '0)
   `PPHF_ASSERT_IMPLY(a_ram_single_access, clock, reset, ram_req.write, !ram_req.read)

endmodule

>>> rtl/core/pphf_ram.sv
// ----------------------------------------------------------------------------
// pphf_ram
// single-port synchronous ram with a registered read
// ----------------------------------------------------------------------------
module pphf_ram #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic                 read_enable,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [DATA_BITS-1:0] write_data,
   output logic [DATA_BITS-1:0] read_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> rtl/core/pphf_csr.sv
// ----------------------------------------------------------------------------
// pphf_csr
// clip window registers behind a plain write port
// ----------------------------------------------------------------------------
module pphf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pphf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pphf_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output pphf_pkg::clip_cfg_type               clip_cfg
);
   import pphf_pkg::*;

   clip_cfg_type cfg_ff;
   clip_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CLIP_LEFT:   cfg_in.left   = csr_write_data[CLIP_X_BITS-1:0];
            CSR_CLIP_RIGHT:  cfg_in.right  = csr_write_data[CLIP_X_BITS-1:0];
            CSR_CLIP_TOP:    cfg_in.top    = csr_write_data[CLIP_Y_BITS-1:0];
            CSR_CLIP_BOTTOM: cfg_in.bottom = csr_write_data[CLIP_Y_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= CLIP_LEFT_RESET;
         cfg_ff.right  <= CLIP_RIGHT_RESET;
         cfg_ff.top    <= CLIP_TOP_RESET;
         cfg_ff.bottom <= CLIP_BOTTOM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign clip_cfg = cfg_ff;

endmodule

>>> rtl/core/pphf_ctrl.sv
// ----------------------------------------------------------------------------
// pphf_ctrl
// command sequencer: clear, reads, clipping, address setup, read-modify-write
// ----------------------------------------------------------------------------
module pphf_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic [pphf_pkg::X_BITS-1:0]        req_x_start,
   input  logic [pphf_pkg::X_BITS-1:0]        req_x_end,
   input  logic [pphf_pkg::X_BITS-1:0]        req_row,
   input  logic [pphf_pkg::COLOR_BITS-1:0]    req_pixel_color,
   input  logic [pphf_pkg::WADDR_BITS-1:0]    req_word_address,
   input  pphf_pkg::clip_cfg_type             clip_cfg,
   output pphf_pkg::ram_req_type              ram_req,
   input  logic [pphf_pkg::WORD_BITS-1:0]     ram_rdata,
   output logic                               rsp_strobe,
   output logic [pphf_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [pphf_pkg::RDATA_BITS-1:0]    rsp_read_data
);
   import pphf_pkg::*;

   localparam logic [X_BITS-1:0] RIGHT_MAX  = X_BITS'(SCREEN_WIDTH - 1);
   localparam logic [X_BITS-1:0] BOTTOM_MAX = X_BITS'(SCREEN_HEIGHT - 1);
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(PIX_PER_WORD - 1);
   localparam logic [FB_ADDR_BITS-1:0] WORD_LAST = FB_ADDR_BITS'(FB_WORDS - 1);

   state_type state_ff, state_in;
   logic [FB_ADDR_BITS-1:0] cur_ff, cur_in;
   logic rsp_strobe_ff, rsp_strobe_in;

   logic [X_BITS-1:0] xs_ff, xs_in, xe_ff, xe_in, row_ff, row_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [FB_ADDR_BITS-1:0] ws_ff, ws_in, we_ff, we_in;
   logic [SLOT_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in, fill_ff, fill_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [RDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [X_BITS-1:0] left_x, right_x, top_y, bottom_y, xs_c, xe_c;
   logic clipped, reject, read_oor, last_word, full_word;
   logic [SLOT_BITS-1:0] lo_w, hi_w;
   logic [WORD_BITS-1:0] mask_w;
   logic [PIX_BITS-1:0] base_pix, pix_start, pix_end;

   // clip window and rejection
   always_comb begin
      left_x   = X_BITS'(clip_cfg.left);
      right_x  = (X_BITS'(clip_cfg.right) > RIGHT_MAX) ? RIGHT_MAX : X_BITS'(clip_cfg.right);
      top_y    = X_BITS'(clip_cfg.top);
      bottom_y = (X_BITS'(clip_cfg.bottom) > BOTTOM_MAX) ? BOTTOM_MAX
                                                         : X_BITS'(clip_cfg.bottom);
      xs_c     = (xs_ff < left_x) ? left_x : xs_ff;
      xe_c     = (xe_ff > right_x) ? right_x : xe_ff;
      clipped  = (xs_ff < left_x) || (xe_ff > right_x);
      reject   = (xs_c > right_x) || (xe_c < left_x) || (xs_c > xe_c) ||
                 (row_ff < top_y) || (row_ff > bottom_y) ||
                 (color_ff > COLOR_BITS'(COLOR_MAX));
   end

   // linear pixel addresses of the span
   always_comb begin
      base_pix  = PIX_BITS'(row_ff[ROW_BITS-1:0]) * PIX_BITS'(SCREEN_WIDTH);
      pix_start = base_pix + PIX_BITS'(xs_ff);
      pix_end   = base_pix + PIX_BITS'(xe_ff);
   end

   // current word mask
   always_comb begin
      lo_w      = (cur_ff == ws_ff) ? lo_ff : '0;
      hi_w      = (cur_ff == we_ff) ? hi_ff : SLOT_LAST;
      full_word = (lo_w == '0) && (hi_w == SLOT_LAST);
      mask_w    = span_mask(lo_w, hi_w);
      last_word = (cur_ff == we_ff);
      read_oor  = (req_word_address >= WADDR_BITS'(FB_WORDS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cur_ff == WORD_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_READ) begin
                  state_in = read_oor ? ST_IDLE : ST_READ;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_CHECK: state_in = reject ? ST_IDLE : ST_ADDR;
         ST_ADDR:  state_in = ST_WORD;
         ST_WORD: begin
            if (!full_word) state_in = ST_MERGE;
            else if (last_word) state_in = ST_IDLE;
         end
         ST_MERGE: state_in = last_word ? ST_IDLE : ST_WORD;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cur_in        = cur_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      row_in        = row_ff;
      color_in      = color_ff;
      status_in     = status_ff;
      ws_in         = ws_ff;
      we_in         = we_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mask_in       = mask_ff;
      fill_in       = fill_ff;
      ram_req       = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_req.write   = 1'b1;
            ram_req.address = cur_ff;
            cur_in          = cur_ff + 1'b1;
         end
         ST_IDLE: begin
            xs_in    = req_x_start;
            xe_in    = req_x_end;
            row_in   = req_row;
            color_in = req_pixel_color;
            if (start && req_command == CMD_READ) begin
               if (read_oor) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_REJECT;
                  rsp_data_in   = '0;
               end else begin
                  ram_req.read    = 1'b1;
                  ram_req.address = req_word_address[FB_ADDR_BITS-1:0];
               end
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = RDATA_BITS'(ram_rdata);
         end
         ST_CHECK: begin
            xs_in     = xs_c;
            xe_in     = xe_c;
            status_in = clipped ? STATUS_CLIPPED : STATUS_OK;
            fill_in   = fill_word(color_ff[BITS_PER_PIXEL-1:0]);
            if (reject) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_REJECT;
               rsp_data_in   = '0;
            end
         end
         ST_ADDR: begin
            ws_in  = FB_ADDR_BITS'(pix_start / PIX_PER_WORD);
            we_in  = FB_ADDR_BITS'(pix_end / PIX_PER_WORD);
            lo_in  = SLOT_BITS'(pix_start % PIX_PER_WORD);
            hi_in  = SLOT_BITS'(pix_end % PIX_PER_WORD);
            cur_in = FB_ADDR_BITS'(pix_start / PIX_PER_WORD);
         end
         ST_WORD: begin
            mask_in         = mask_w;
            ram_req.address = cur_ff;
            if (full_word) begin
               ram_req.write = 1'b1;
               ram_req.data  = fill_ff & mask_w;
               cur_in        = cur_ff + 1'b1;
               if (last_word) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = status_ff;
                  rsp_data_in   = '0;
               end
            end else begin
               ram_req.read = 1'b1;
            end
         end
         ST_MERGE: begin
            ram_req.write   = 1'b1;
            ram_req.address = cur_ff;
            ram_req.data    = (ram_rdata & ~mask_ff) | (fill_ff & mask_ff);
            cur_in          = cur_ff + 1'b1;
            if (last_word) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cur_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff         <= xs_in;
      xe_ff         <= xe_in;
      row_ff        <= row_in;
      color_ff      <= color_in;
      status_ff     <= status_in;
      ws_ff         <= ws_in;
      we_ff         <= we_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mask_ff       <= mask_in;
      fill_ff       <= fill_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

>>> tb/packed_pixel_hline_fill_tb.sv
// ----------------------------------------------------------------------------
// packed_pixel_hline_fill_tb
// self-checking bench for the packed-pixel horizontal span fill block
//
// line draws and word reads go through the start/busy command port, under a
// series of clip windows written through the csr port while the block is
// idle. a shadow framebuffer and clip window in the bench predict the status
// and read data of every item, and each rsp_strobe result is checked against
// the oldest prediction. directed passes cover the edge cases, then random
// phases run mostly in-window spans plus reads aimed at recently drawn rows.
// ----------------------------------------------------------------------------
module packed_pixel_hline_fill_tb;
   import pphf_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                   command;
      logic [X_BITS-1:0]      x_start;
      logic [X_BITS-1:0]      x_end;
      logic [X_BITS-1:0]      row;
      logic [COLOR_BITS-1:0]  pixel_color;
      logic [WADDR_BITS-1:0]  word_address;
   } span_item_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [RDATA_BITS-1:0]  read_data;
   } span_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_command = CMD_DRAW;
   logic [X_BITS-1:0]         req_x_start = '0;
   logic [X_BITS-1:0]         req_x_end = '0;
   logic [X_BITS-1:0]         req_row = '0;
   logic [COLOR_BITS-1:0]     req_pixel_color = '0;
   logic [WADDR_BITS-1:0]     req_word_address = '0;
   logic                      rsp_strobe;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [RDATA_BITS-1:0]     rsp_read_data;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CLIP_LEFT;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   packed_pixel_hline_fill dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_row          (req_row),
      .req_pixel_color  (req_pixel_color),
      .req_word_address (req_word_address),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow state
   logic [WORD_BITS-1:0]   fb_shadow [FB_WORDS];
   logic [CLIP_X_BITS-1:0] win_left = CLIP_LEFT_RESET;
   logic [CLIP_X_BITS-1:0] win_right = CLIP_RIGHT_RESET;
   logic [CLIP_Y_BITS-1:0] win_top = CLIP_TOP_RESET;
   logic [CLIP_Y_BITS-1:0] win_bottom = CLIP_BOTTOM_RESET;

   span_item_type   pending_spans [$];
   span_result_type results_due [$];
   int              recent_rows [$];

   int  cycle_count = 0;
   int  items_queued = 0;
   int  items_accepted = 0;
   int  mismatch_count = 0;
   int  window_count = 0;
   int  draw_count = 0;
   int  clipped_count = 0;
   int  reject_count = 0;
   int  read_count = 0;
   int  bad_read_count = 0;
   int  gap_left = 0;
   bit  gap_free = 1'b0;
   bit  took = 1'b0;

   initial begin
      foreach (fb_shadow[i]) fb_shadow[i] = '0;
   end

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic span_result_type apply_span_command(input span_item_type it);
      span_result_type r;
      int  xs;
      int  xe;
      int  right_eff;
      int  bottom_eff;
      int  pix;
      bit  clipped;
      r.status = STATUS_OK;
      r.read_data = '0;
      if (it.command == CMD_READ) begin
         if (int'(it.word_address) >= FB_WORDS) r.status = STATUS_REJECT;
         else r.read_data = fb_shadow[it.word_address];
         return r;
      end
      right_eff = (int'(win_right) > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : int'(win_right);
      bottom_eff = (int'(win_bottom) > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : int'(win_bottom);
      xs = int'(it.x_start);
      xe = int'(it.x_end);
      clipped = 1'b0;
      if (xs < int'(win_left)) begin
         xs = int'(win_left);
         clipped = 1'b1;
      end
      if (xe > right_eff) begin
         xe = right_eff;
         clipped = 1'b1;
      end
      if (xs > right_eff || xe < int'(win_left) || xs > xe ||
          int'(it.row) < int'(win_top) || int'(it.row) > bottom_eff ||
          int'(it.pixel_color) > COLOR_MAX) begin
         r.status = STATUS_REJECT;
         return r;
      end
      for (int x = xs; x <= xe; x++) begin
         pix = int'(it.row) * SCREEN_WIDTH + x;
         fb_shadow[pix / PIX_PER_WORD]
            [(PIX_PER_WORD - 1 - pix % PIX_PER_WORD) * BITS_PER_PIXEL +: BITS_PER_PIXEL]
            = it.pixel_color[BITS_PER_PIXEL-1:0];
      end
      r.status = clipped ? STATUS_CLIPPED : STATUS_OK;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (gap_free) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // driver
   always @(negedge clock) begin
      span_item_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_spans.size() != 0) begin
            nxt = pending_spans.pop_front();
            req_command <= nxt.command;
            req_x_start <= nxt.x_start;
            req_x_end <= nxt.x_end;
            req_row <= nxt.row;
            req_pixel_color <= nxt.pixel_color;
            req_word_address <= nxt.word_address;
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string what, input span_result_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("cycle %0d %s: expected status %0d data %h, got status %0d data %h",
                  cycle_count, what, want.status, want.read_data, rsp_status, rsp_read_data);
   endtask

   // monitor and predictor hookup
   always @(posedge clock) begin
      span_result_type want;
      span_item_type   seen;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_strobe) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with no item pending", '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_status !== want.status || rsp_read_data !== want.read_data)
                  report_mismatch("result differs", want);
            end
         end
         if (start && !busy) begin
            seen = '{req_command, req_x_start, req_x_end, req_row, req_pixel_color,
                     req_word_address};
            want = apply_span_command(seen);
            results_due.push_back(want);
            items_accepted <= items_accepted + 1;
            if (seen.command == CMD_READ) begin
               read_count++;
               if (want.status == STATUS_REJECT) bad_read_count++;
            end else begin
               draw_count++;
               if (want.status == STATUS_CLIPPED) clipped_count++;
               if (want.status == STATUS_REJECT) reject_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycle_count, results_due.size());
         $display("packed_pixel_hline_fill: mismatch");
         $finish;
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (items_accepted != items_queued || results_due.size() != 0 || busy !== 1'b0);
   endtask

   task automatic set_window(input logic [CSR_DATA_BITS-1:0] left,
                             input logic [CSR_DATA_BITS-1:0] right,
                             input logic [CSR_DATA_BITS-1:0] top,
                             input logic [CSR_DATA_BITS-1:0] bottom);
      logic [CSR_INDEX_BITS-1:0] idx [4];
      logic [CSR_DATA_BITS-1:0]  val [4];
      idx = '{CSR_CLIP_LEFT, CSR_CLIP_RIGHT, CSR_CLIP_TOP, CSR_CLIP_BOTTOM};
      val = '{left, right, top, bottom};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      win_left = left;
      win_right = right;
      win_top = top[CLIP_Y_BITS-1:0];
      win_bottom = bottom[CLIP_Y_BITS-1:0];
      window_count++;
   endtask

   task automatic queue_item(input span_item_type it);
      pending_spans.push_back(it);
      items_queued++;
   endtask

   task automatic queue_draw(input int xs, input int xe, input int row, input int color);
      queue_item('{CMD_DRAW, X_BITS'(xs), X_BITS'(xe), X_BITS'(row), COLOR_BITS'(color),
                   WADDR_BITS'($urandom)});
   endtask

   task automatic queue_read(input int addr);
      queue_item('{CMD_READ, X_BITS'($urandom), X_BITS'($urandom), X_BITS'($urandom),
                   COLOR_BITS'($urandom), WADDR_BITS'(addr)});
   endtask

   function automatic span_item_type random_span_item();
      span_item_type it;
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      int sel;
      int xs;
      int xe;
      int row;
      it = '{CMD_DRAW, X_BITS'($urandom), X_BITS'($urandom), X_BITS'($urandom),
             COLOR_BITS'($urandom), WADDR_BITS'($urandom)};
      if ($urandom_range(0, 99) < 35) begin
         it.command = CMD_READ;
         sel = $urandom_range(0, 9);
         if (sel < 6 && recent_rows.size() != 0)
            it.word_address = WADDR_BITS'(recent_rows[$urandom_range(0, recent_rows.size() - 1)]
                              * (SCREEN_WIDTH / PIX_PER_WORD) + $urandom_range(0, 79));
         else if (sel < 8) it.word_address = WADDR_BITS'($urandom_range(0, FB_WORDS - 1));
         else if (sel < 9) it.word_address = WADDR_BITS'($urandom_range(FB_WORDS, 65535));
         else it.word_address = WADDR_BITS'($urandom_range(0, 65535));
         return it;
      end
      lo_x = int'(win_left);
      hi_x = (int'(win_right) > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : int'(win_right);
      if (lo_x > hi_x) begin
         lo_x = 0;
         hi_x = SCREEN_WIDTH - 1;
      end
      lo_y = int'(win_top);
      hi_y = (int'(win_bottom) > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : int'(win_bottom);
      if (lo_y > hi_y) begin
         lo_y = 0;
         hi_y = SCREEN_HEIGHT - 1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         xs = $urandom_range(lo_x, hi_x);
         xe = xs + $urandom_range(0, 24);
      end else if (sel < 60) begin
         xs = $urandom_range(0, lo_x);
         xe = xs + $urandom_range(0, 40);
      end else if (sel < 70) begin
         xs = $urandom_range(lo_x, hi_x);
         xe = $urandom_range(hi_x, 4095);
      end else if (sel < 78) begin
         xs = $urandom_range(0, 40);
         xe = $urandom_range(600, 700);
      end else if (sel < 86) begin
         xs = $urandom_range(1, 4095);
         xe = $urandom_range(0, xs - 1);
      end else if (sel < 93) begin
         xs = $urandom_range(lo_x, hi_x);
         xe = xs;
      end else begin
         xs = $urandom_range(0, 4095);
         xe = $urandom_range(0, 4095);
      end
      sel = $urandom_range(0, 99);
      if (sel < 85) row = $urandom_range(lo_y, hi_y);
      else if (sel < 93) row = $urandom_range(0, SCREEN_HEIGHT - 1);
      else row = $urandom_range(0, 4095);
      it.x_start = X_BITS'(xs);
      it.x_end = X_BITS'(xe);
      it.row = X_BITS'(row);
      if ($urandom_range(0, 99) < 88) it.pixel_color = COLOR_BITS'($urandom_range(0, COLOR_MAX));
      if (row < SCREEN_HEIGHT) begin
         recent_rows.push_back(row);
         if (recent_rows.size() > 16) void'(recent_rows.pop_front());
      end
      return it;
   endfunction

   task automatic run_random_phase(input int count, input bit no_gaps);
      gap_free = no_gaps;
      for (int i = 0; i < count; i++) queue_item(random_span_item());
      drain();
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_x_limit(input int lo);
      return CSR_DATA_BITS'($urandom_range(lo, 1023));
   endfunction

   task automatic random_window();
      int left;
      int top;
      left = $urandom_range(0, SCREEN_WIDTH - 1);
      top = $urandom_range(0, SCREEN_HEIGHT - 1);
      set_window(CSR_DATA_BITS'(left), random_x_limit(left),
                 {1'($urandom), CLIP_Y_BITS'(top)},
                 {1'($urandom), CLIP_Y_BITS'($urandom_range(top, 511))});
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (busy !== 1'b0);

      // reset window: cleared memory, full row, edge words, rejects
      queue_read(0);
      queue_read(FB_WORDS - 1);
      queue_read(FB_WORDS);
      queue_read(65535);
      queue_draw(0, 639, 0, COLOR_MAX);
      queue_read(0);
      queue_draw(3, 12, 1, 5);
      queue_read(80);
      queue_read(81);
      queue_draw(0, 0, 479, 1);
      queue_draw(639, 639, 479, 2);
      queue_read(479 * 80);
      queue_read(FB_WORDS - 1);
      queue_draw(20, 30, 2, 16);
      queue_draw(20, 30, 2, 255);
      queue_draw(20, 30, 480, 3);
      queue_draw(20, 30, 4095, 3);
      queue_draw(4095, 4095, 2, 3);
      queue_draw(10, 5, 2, 3);
      queue_draw(600, 4095, 2, 9);
      queue_draw(17, 18, 2, 0);
      queue_read(162);
      queue_read(239);
      queue_draw(8, 15, 3, 10);
      queue_read(241);
      drain();

      // window past the screen edge, left clip, masked top and bottom bits
      set_window(100, 1023, 10'h205, 10'h3FF);
      queue_draw(0, 4095, 5, 3);
      queue_draw(0, 50, 6, 4);
      queue_draw(200, 300, 4, 4);
      queue_read(5 * 80 + 12);
      queue_draw(100, 639, 479, 7);
      queue_read(479 * 80 + 79);
      drain();

      random_window();
      run_random_phase(90, 1'b0);
      set_window(0, 1023, 10'h200, 10'h3FF);
      run_random_phase(90, 1'b1);
      set_window(639, 639, 479, 479);
      run_random_phase(40, 1'b0);
      random_window();
      run_random_phase(90, 1'b0);
      set_window(10'h3FF, 0, 10'h1FF, 0);
      run_random_phase(20, 1'b0);
      random_window();
      run_random_phase(90, 1'b1);
      set_window(0, 0, 0, 0);
      run_random_phase(20, 1'b0);
      set_window(0, 639, 0, 479);
      run_random_phase(80, 1'b0);

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (results_due.size() != 0) begin
         $display("%0d results never arrived", results_due.size());
         mismatch_count += results_due.size();
      end
      $display("covered %0d line draws (%0d clipped, %0d rejected) and %0d word reads",
               draw_count, clipped_count, reject_count, read_count);
      $display("(%0d out of range) over %0d clip windows, %0d mismatches",
               bad_read_count, window_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("packed_pixel_hline_fill: match");
      end else begin
         $display("packed_pixel_hline_fill: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pphf_pkg.sv
rtl/core/pphf_ram.sv
rtl/core/pphf_csr.sv
rtl/core/pphf_ctrl.sv
rtl/core/packed_pixel_hline_fill.sv
tb/packed_pixel_hline_fill_tb.sv
